### sv/qtl_pkg.sv
// qtl_pkg: shared types and constants of the q-table learning engine
// request and response payloads, configuration register image and codes
// no dependencies
package qtl_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned OUT_TUSER_W = 2;

  localparam logic [16:0] ONE_Q16 = 17'd65536;

  // register reset values
  localparam logic [16:0] LEARN_RATE_RST    = 17'd6554;
  localparam logic [16:0] DISCOUNT_RST      = 17'd58982;
  localparam logic [16:0] EXPLORE_DECAY_RST = 17'd65208;
  localparam logic [16:0] EXPLORE_FLOOR_RST = 17'd655;
  localparam logic [16:0] EXPLORE_START_RST = 17'd65536;
  localparam logic [8:0]  STATES_RST        = 9'd256;
  localparam logic [3:0]  ACTIONS_RST       = 4'd8;

  localparam logic REQ_CHOOSE = 1'b0;
  localparam logic REQ_UPDATE = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARN_RATE    = 3'd0,
    CFG_DISCOUNT      = 3'd1,
    CFG_EXPLORE_DECAY = 3'd2,
    CFG_EXPLORE_FLOOR = 3'd3,
    CFG_EXPLORE_START = 3'd4,
    CFG_STATES        = 3'd5,
    CFG_ACTIONS       = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [16:0] learn_rate;
    logic [16:0] discount;
    logic [16:0] explore_decay;
    logic [16:0] explore_floor;
    logic [16:0] explore_start;
    logic [8:0]  states_in_use;
    logic [3:0]  actions_in_use;
    logic        start_load;
  } cfg_t;

  typedef struct packed {
    logic               req_type;
    logic [7:0]         cur_state;
    logic [2:0]         taken_action;
    logic signed [31:0] reward_value;
    logic [7:0]         following_state;
    logic               episode_done;
    logic [15:0]        random_draw;
    logic [2:0]         random_action;
  } req_t;

  typedef struct packed {
    logic [2:0]         chosen_action;
    logic               explored;
    logic signed [31:0] new_q_value;
    logic [16:0]        explore_rate_now;
    logic               saturated;
  } rsp_t;

endpackage

### sv/qtl_cfg.sv
// qtl_cfg: configuration register file of the q-table learning engine
// rates are clamped to 1.0 on write; depends on qtl_pkg
module qtl_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [qtl_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [qtl_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  output qtl_pkg::cfg_t                    cfg_o
);
  import qtl_pkg::*;

  logic [16:0] learn_q, discount_q, decay_q, floor_q, start_q;
  logic [8:0]  states_q;
  logic [3:0]  actions_q;
  logic        load_q;
  logic [16:0] rate_sat;
  logic        wr;

  assign cfg_ready_o = 1'b1;
  assign wr          = cfg_valid_i && cfg_ready_o;
  assign rate_sat    = (cfg_data_i > ONE_Q16) ? ONE_Q16 : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learn_q    <= LEARN_RATE_RST;
      discount_q <= DISCOUNT_RST;
      decay_q    <= EXPLORE_DECAY_RST;
      floor_q    <= EXPLORE_FLOOR_RST;
      start_q    <= EXPLORE_START_RST;
      states_q   <= STATES_RST;
      actions_q  <= ACTIONS_RST;
      load_q     <= 1'b0;
    end else begin
      load_q <= 1'b0;
      if (wr) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_LEARN_RATE:    learn_q    <= rate_sat;
          CFG_DISCOUNT:      discount_q <= rate_sat;
          CFG_EXPLORE_DECAY: decay_q    <= rate_sat;
          CFG_EXPLORE_FLOOR: floor_q    <= rate_sat;
          CFG_EXPLORE_START: begin
            start_q <= rate_sat;
            load_q  <= 1'b1;
          end
          CFG_STATES:        states_q   <= cfg_data_i[8:0];
          CFG_ACTIONS:       actions_q  <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  assign cfg_o = '{learn_rate:     learn_q,
                   discount:       discount_q,
                   explore_decay:  decay_q,
                   explore_floor:  floor_q,
                   explore_start:  start_q,
                   states_in_use:  states_q,
                   actions_in_use: actions_q,
                   start_load:     load_q};

endmodule

### sv/qtl_table.sv
// qtl_table: q-value store, one write port and one read port, registered read data
// no dependencies
module qtl_table #(
  parameter int unsigned ADDR_W = 11
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [ADDR_W-1:0]   waddr_i,
  input  logic signed [31:0]  wdata_i,
  input  logic [ADDR_W-1:0]   raddr_i,
  output logic signed [31:0]  rdata_o
);

  logic signed [31:0] mem_q [2**ADDR_W];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### sv/qtl_core.sv
// qtl_core: request sequencer and datapath of the q-table learning engine
// row scan, fixed-point update, exploration rate; depends on qtl_pkg and drives qtl_table
module qtl_core #(
  parameter  int unsigned MAX_STATES  = 256,
  parameter  int unsigned MAX_ACTIONS = 8,
  localparam int unsigned SW          = $clog2(MAX_STATES),
  localparam int unsigned AW          = $clog2(MAX_ACTIONS),
  localparam int unsigned ADDR_W      = SW + AW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  qtl_pkg::cfg_t              cfg_i,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  qtl_pkg::req_t              req_i,
  output logic                       rsp_valid_o,
  input  logic                       rsp_ready_i,
  output qtl_pkg::rsp_t              rsp_o,
  output logic                       mem_we_o,
  output logic [ADDR_W-1:0]          mem_waddr_o,
  output logic signed [31:0]         mem_wdata_o,
  output logic [ADDR_W-1:0]          mem_raddr_o,
  input  logic signed [31:0]         mem_rdata_i
);
  import qtl_pkg::*;

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_SCAN  = 10'b0000000100,
    ST_ENTRY = 10'b0000001000,
    ST_TAIL  = 10'b0000010000,
    ST_MUL1  = 10'b0000100000,
    ST_DIFF  = 10'b0001000000,
    ST_MUL2  = 10'b0010000000,
    ST_WRITE = 10'b0100000000,
    ST_DONE  = 10'b1000000000
  } state_e;

  localparam logic [16:0] MaxStates  = 17'(MAX_STATES);
  localparam logic [6:0]  MaxActions = 7'(MAX_ACTIONS);

  state_e state_q, state_d;

  logic [ADDR_W-1:0]   clr_cnt_q;
  logic                is_upd_q, done_q;
  logic [SW-1:0]       row_q;
  logic [ADDR_W-1:0]   ent_addr_q;
  logic [AW-1:0]       act_q, rand_act_q;
  logic signed [31:0]  reward_q;
  logic [15:0]         draw_q;

  logic [AW-1:0]       rd_idx_q, rd_pos_q, max_idx_q;
  logic                rd_vld_q, rd_first_q;
  logic signed [31:0]  max_q, q_old_q;
  logic signed [49:0]  prod1_q;
  logic signed [34:0]  diff_q;
  logic signed [52:0]  prod2_q;
  logic [16:0]         rate_q;

  logic [2:0]          res_action_q;
  logic signed [31:0]  res_q_q;
  logic                res_sat_q;
  logic                out_valid_q;
  rsp_t                out_q;

  // effective counts
  logic [16:0] ns;
  logic [6:0]  na;
  logic [16:0] st17, nx17;
  logic [6:0]  ac7, ra7;
  logic        accept;

  always_comb begin
    ns = (cfg_i.states_in_use == 9'd0) ? 17'd1 : 17'(cfg_i.states_in_use);
    if (ns > MaxStates) ns = MaxStates;
    na = (cfg_i.actions_in_use == 4'd0) ? 7'd1 : 7'(cfg_i.actions_in_use);
    if (na > MaxActions) na = MaxActions;
    st17 = (17'(req_i.cur_state) >= ns) ? ns - 17'd1 : 17'(req_i.cur_state);
    nx17 = (17'(req_i.following_state) >= ns) ? ns - 17'd1 : 17'(req_i.following_state);
    ac7  = (7'(req_i.taken_action) >= na) ? na - 7'd1 : 7'(req_i.taken_action);
    ra7  = (7'(req_i.random_action) >= na) ? na - 7'd1 : 7'(req_i.random_action);
  end

  assign req_ready_o = (state_q == ST_IDLE);
  assign accept      = req_valid_i && req_ready_o;

  logic scan_last;
  assign scan_last = (7'(rd_idx_q) == na - 7'd1);

  // update arithmetic
  logic signed [49:0] sum1;
  logic signed [33:0] round1;
  logic signed [52:0] sum2;
  logic signed [36:0] delta;
  logic signed [37:0] nq;
  logic signed [31:0] nq_sat;
  logic               nq_clip;

  always_comb begin
    sum1    = prod1_q + 50'sd32768;
    round1  = sum1[49:16];
    sum2    = prod2_q + 53'sd32768;
    delta   = sum2[52:16];
    nq      = 38'(q_old_q) + 38'(delta);
    nq_clip = 1'b0;
    nq_sat  = nq[31:0];
    if (nq > 38'sd2147483647) begin
      nq_sat  = 32'sh7fffffff;
      nq_clip = 1'b1;
    end else if (nq < -38'sd2147483648) begin
      nq_sat  = 32'sh80000000;
      nq_clip = 1'b1;
    end
  end

  // exploration rate refresh
  logic [16:0] rate_base, rate_dec, rate_next;
  logic [33:0] rate_prod;
  logic [17:0] rate_rnd;

  always_comb begin
    rate_base = (rate_q <= cfg_i.explore_floor || done_q) ? ONE_Q16 : rate_q;
    rate_prod = 34'(rate_base) * 34'(cfg_i.explore_decay) + 34'd32768;
    rate_rnd  = rate_prod[33:16];
    rate_dec  = (rate_rnd > 18'(ONE_Q16)) ? ONE_Q16 : rate_rnd[16:0];
    rate_next = (rate_base > cfg_i.explore_floor) ? rate_dec : rate_base;
  end

  // choose result
  logic       explore_hit;
  logic [6:0] pick7;
  assign explore_hit = (17'(draw_q) < rate_q);
  assign pick7       = explore_hit ? 7'(rand_act_q) : 7'(max_idx_q);

  // table port
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = ent_addr_q;
    mem_wdata_o = nq_sat;
    mem_raddr_o = {row_q, rd_idx_q};
    if (state_q == ST_CLEAR) begin
      mem_we_o    = 1'b1;
      mem_waddr_o = clr_cnt_q;
      mem_wdata_o = '0;
    end else if (state_q == ST_WRITE) begin
      mem_we_o = 1'b1;
    end
    if (state_q == ST_ENTRY) mem_raddr_o = ent_addr_q;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_cnt_q == '1) state_d = ST_IDLE;
      ST_IDLE:  if (accept) state_d = ST_SCAN;
      ST_SCAN:  if (scan_last) state_d = is_upd_q ? ST_ENTRY : ST_TAIL;
      ST_ENTRY: state_d = ST_MUL1;
      ST_TAIL:  state_d = ST_DONE;
      ST_MUL1:  state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_MUL2;
      ST_MUL2:  state_d = ST_WRITE;
      ST_WRITE: state_d = ST_DONE;
      ST_DONE:  if (!out_valid_q || rsp_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
      rate_q      <= ONE_Q16;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == ST_SCAN);
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (cfg_i.start_load) begin
        rate_q <= cfg_i.explore_start;
      end else if (state_q == ST_WRITE) begin
        rate_q <= rate_next;
      end
      if (state_q == ST_DONE && (!out_valid_q || rsp_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_upd_q   <= (req_i.req_type == REQ_UPDATE);
      row_q      <= (req_i.req_type == REQ_UPDATE) ? nx17[SW-1:0] : st17[SW-1:0];
      ent_addr_q <= {st17[SW-1:0], ac7[AW-1:0]};
      act_q      <= ac7[AW-1:0];
      rand_act_q <= ra7[AW-1:0];
      reward_q   <= req_i.reward_value;
      done_q     <= req_i.episode_done;
      draw_q     <= req_i.random_draw;
      rd_idx_q   <= '0;
    end else if (state_q == ST_SCAN && !scan_last) begin
      rd_idx_q <= rd_idx_q + 1'b1;
    end

    rd_first_q <= (rd_idx_q == '0);
    rd_pos_q   <= rd_idx_q;
    // running row maximum, first index wins ties
    if (rd_vld_q && (rd_first_q || mem_rdata_i > max_q)) begin
      max_q     <= mem_rdata_i;
      max_idx_q <= rd_pos_q;
    end

    if (state_q == ST_MUL1) begin
      q_old_q <= mem_rdata_i;
      prod1_q <= 50'($signed({1'b0, cfg_i.discount})) * 50'(max_q);
    end
    if (state_q == ST_DIFF) diff_q <= 35'(reward_q) + 35'(round1) - 35'(q_old_q);
    if (state_q == ST_MUL2) prod2_q <= 53'($signed({1'b0, cfg_i.learn_rate})) * 53'(diff_q);
    if (state_q == ST_WRITE) begin
      res_action_q <= 3'(7'(act_q));
      res_q_q      <= nq_sat;
      res_sat_q    <= nq_clip;
    end

    if (state_q == ST_DONE && (!out_valid_q || rsp_ready_i)) begin
      out_q.explore_rate_now <= rate_q;
      if (is_upd_q) begin
        out_q.chosen_action <= res_action_q;
        out_q.explored      <= 1'b0;
        out_q.new_q_value   <= res_q_q;
        out_q.saturated     <= res_sat_q;
      end else begin
        out_q.chosen_action <= pick7[2:0];
        out_q.explored      <= explore_hit;
        out_q.new_q_value   <= max_q;
        out_q.saturated     <= 1'b0;
      end
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

`ifndef NO_ASSERTIONS
  a_we_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we_o |-> (state_q == ST_CLEAR || state_q == ST_WRITE))
    else $error("table written outside clear or write step");
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_ready_o |-> (state_q == ST_IDLE && !rd_vld_q))
    else $error("request taken while busy");
  a_rate_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rate_q <= ONE_Q16)
    else $error("exploration rate above one");
  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (7'(rd_idx_q) < na))
    else $error("row scan beyond actions in use");
  a_write_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |=> (state_q == ST_DONE))
    else $error("write step not followed by result");
`endif

endmodule

### sv/q_table_learning_engine_unit.sv
// q_table_learning_engine_unit: top level of the tabular q-learning engine
// packs the stream buses; instantiates qtl_cfg, qtl_table, qtl_core; depends on qtl_pkg
// usage:
//   s_axis_* carries one request per beat: tuser is the request kind (0 choose
//   action, 1 update entry), tlast marks the end of an episode on an update.
//   m_axis_* returns exactly one result per request, in request order.
//   cfg_* writes one of seven registers by index; always ready. write only
//   while no request is in flight.
// request handling:
//   one request at a time. m_axis_tvalid rises when a result is ready, and
//   s_axis_tready rises with it: a new request is taken only after the last
//   one has finished. a choose walks the row through the single read port
//   (one entry per cycle); an update walks the following state's row the same
//   way, then reads the entry and goes through the two registered multiplies.
// reset:
//   the q table is zeroed by a sweep of all 2**(clog2(MAX_STATES)+clog2(MAX_ACTIONS))
//   entries (2048 by default), during which s_axis_tready stays low; registers
//   and the exploration rate take their defaults at once.
// stall:
//   a finished result waits in the output register while m_axis_tready is
//   low; the next request is still accepted and held at its last step.
module q_table_learning_engine_unit #(
  parameter int unsigned MAX_STATES  = 256,
  parameter int unsigned MAX_ACTIONS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // request stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // cur_state[7:0], taken_action[10:8], reward_value[42:11],
  // following_state[50:43], random_draw[66:51], random_action[69:67], zero fill
  input  logic [qtl_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  input  logic                                s_axis_tuser,   // req_type
  input  logic                                s_axis_tlast,   // episode_done
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // chosen_action[2:0], new_q_value[34:3], explore_rate_now[51:35], zero fill
  output logic [qtl_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
  // explored[0], saturated[1]
  output logic [qtl_pkg::OUT_TUSER_W-1:0]     m_axis_tuser,
  // configuration writes
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [qtl_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [qtl_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import qtl_pkg::*;

  localparam int unsigned ADDR_W = $clog2(MAX_STATES) + $clog2(MAX_ACTIONS);

  cfg_t cfg;
  req_t req;
  rsp_t rsp;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr, mem_raddr;
  logic signed [31:0]  mem_wdata, mem_rdata;

  // unpack the request
  assign req.req_type        = s_axis_tuser;
  assign req.cur_state       = s_axis_tdata[7:0];
  assign req.taken_action    = s_axis_tdata[10:8];
  assign req.reward_value    = s_axis_tdata[42:11];
  assign req.following_state = s_axis_tdata[50:43];
  assign req.episode_done    = s_axis_tlast;
  assign req.random_draw     = s_axis_tdata[66:51];
  assign req.random_action   = s_axis_tdata[69:67];

  // pack the result
  assign m_axis_tdata = {4'b0, rsp.explore_rate_now, rsp.new_q_value, rsp.chosen_action};
  assign m_axis_tuser = {rsp.saturated, rsp.explored};

  qtl_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  qtl_table #(
    .ADDR_W (ADDR_W)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  qtl_core #(
    .MAX_STATES  (MAX_STATES),
    .MAX_ACTIONS (MAX_ACTIONS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .req_i       (req),
    .rsp_valid_o (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .rsp_o       (rsp),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

endmodule

### sim/q_table_learning_engine_unit_tb.sv
// q_table_learning_engine_unit_tb: self-checking bench for the q-table learning engine
// keeps a mirror of the q table and exploration rate, predicts every result, checks in order
// depends on qtl_pkg and q_table_learning_engine_unit
module q_table_learning_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import qtl_pkg::*;

  localparam int MAX_ROWS = 256;
  localparam int MAX_ACTS = 8;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
  logic                    s_axis_tuser = 1'b0;
  logic                    s_axis_tlast = 1'b0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic [OUT_TUSER_W-1:0]  m_axis_tuser;
  logic                    cfg_valid_i = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;

  // idle mix and long receiver hold-off
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles_left = 0;
  int round_no = 0;
  int mismatch_count = 0;

  // mirror of the engine
  logic [16:0]        lr_q, disc_q, decay_q, floor_q, start_q, rate_q;
  logic [8:0]         rows_cfg;
  logic [3:0]         acts_cfg;
  logic signed [31:0] q_mirror [0:MAX_ROWS*MAX_ACTS-1];

  rsp_t awaited_rsp[$];

  q_table_learning_engine_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5ns clk_i = ~clk_i;

  initial begin
    #5ms;
    $display("q_table_learning_engine_unit test failed");
    $finish;
  end

  //--------------------------------------------------------------------------
  // prediction
  //--------------------------------------------------------------------------
  function automatic logic [16:0] cap_one(logic [16:0] v);
    return (v > ONE_Q16) ? ONE_Q16 : v;
  endfunction

  // nearest, ties toward plus infinity
  function automatic longint round_q16(longint v);
    return (v + 64'sd32768) >>> 16;
  endfunction

  function automatic int active_rows();
    int n;
    n = rows_cfg;
    if (n < 1) n = 1;
    if (n > MAX_ROWS) n = MAX_ROWS;
    return n;
  endfunction

  function automatic int active_actions();
    int n;
    n = acts_cfg;
    if (n < 1) n = 1;
    if (n > MAX_ACTS) n = MAX_ACTS;
    return n;
  endfunction

  function automatic int clip_index(int v, int n);
    return (v >= n) ? n - 1 : v;
  endfunction

  // row maximum, lowest index wins a tie
  function automatic logic signed [31:0] row_peak(int row, int acts, output int idx);
    logic signed [31:0] best;
    int i;
    best = q_mirror[row*MAX_ACTS];
    idx = 0;
    for (i = 1; i < acts; i++) begin
      if (q_mirror[row*MAX_ACTS+i] > best) begin
        best = q_mirror[row*MAX_ACTS+i];
        idx = i;
      end
    end
    return best;
  endfunction

  function automatic void apply_register_write(cfg_idx_e idx, logic [16:0] data);
    case (idx)
      CFG_LEARN_RATE:    lr_q = cap_one(data);
      CFG_DISCOUNT:      disc_q = cap_one(data);
      CFG_EXPLORE_DECAY: decay_q = cap_one(data);
      CFG_EXPLORE_FLOOR: floor_q = cap_one(data);
      CFG_EXPLORE_START: begin
        start_q = cap_one(data);
        rate_q = start_q;
      end
      CFG_STATES:        rows_cfg = data[8:0];
      CFG_ACTIONS:       acts_cfg = data[3:0];
      default: ;
    endcase
  endfunction

  // advances the mirror by one request and returns the result it yields
  function automatic rsp_t next_q_response(req_t r);
    rsp_t o;
    int rows, acts, s, a, nx, k, pos;
    logic signed [31:0] best;
    longint q, target, delta, nq, scaled, rew;
    rows = active_rows();
    acts = active_actions();
    s = clip_index(r.cur_state, rows);
    o = '0;
    if (r.req_type == REQ_CHOOSE) begin
      best = row_peak(s, acts, k);
      o.new_q_value = best;
      if ({1'b0, r.random_draw} < rate_q) begin
        o.explored = 1'b1;
        k = clip_index(r.random_action, acts);
      end
      o.chosen_action = k[2:0];
    end else begin
      a = clip_index(r.taken_action, acts);
      nx = clip_index(r.following_state, rows);
      best = row_peak(nx, acts, k);
      pos = s*MAX_ACTS + a;
      q = q_mirror[pos];
      rew = $signed(r.reward_value);
      target = rew + round_q16(longint'(disc_q) * longint'(best));
      delta = round_q16(longint'(lr_q) * (target - q));
      nq = q + delta;
      if (nq > Q_MAX) begin
        nq = Q_MAX;
        o.saturated = 1'b1;
      end
      if (nq < Q_MIN) begin
        nq = Q_MIN;
        o.saturated = 1'b1;
      end
      q_mirror[pos] = nq[31:0];
      o.new_q_value = nq[31:0];
      o.chosen_action = a[2:0];
      // episode end or exhausted exploration restarts at 1.0, then decay
      if (rate_q <= floor_q || r.episode_done) rate_q = ONE_Q16;
      if (rate_q > floor_q) begin
        scaled = (longint'(rate_q) * longint'(decay_q) + 64'sd32768) >>> 16;
        rate_q = (scaled > ONE_Q16) ? ONE_Q16 : scaled[16:0];
      end
    end
    o.explore_rate_now = rate_q;
    return o;
  endfunction

  //--------------------------------------------------------------------------
  // checking
  //--------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= 50)
      $display("%0t ns: %s mismatch, got %0d expected %0d", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : check_results
    rsp_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got.chosen_action    = m_axis_tdata[2:0];
      got.new_q_value      = m_axis_tdata[34:3];
      got.explore_rate_now = m_axis_tdata[51:35];
      got.explored         = m_axis_tuser[0];
      got.saturated        = m_axis_tuser[1];
      if (awaited_rsp.size() == 0) begin
        report_mismatch("unrequested result", 1, 0);
      end else begin
        want = awaited_rsp.pop_front();
        if (got.chosen_action != want.chosen_action)
          report_mismatch("chosen_action", got.chosen_action, want.chosen_action);
        if (got.explored != want.explored)
          report_mismatch("explored", got.explored, want.explored);
        if (got.new_q_value != want.new_q_value)
          report_mismatch("new_q_value", got.new_q_value, want.new_q_value);
        if (got.explore_rate_now != want.explore_rate_now)
          report_mismatch("explore_rate_now", got.explore_rate_now, want.explore_rate_now);
        if (got.saturated != want.saturated)
          report_mismatch("saturated", got.saturated, want.saturated);
      end
    end
  end

  // receiver: random stalls, or a counted hold-off when one is asked for
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_cycles_left > 0) begin
        m_axis_tready <= 1'b0;
        hold_cycles_left--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  //--------------------------------------------------------------------------
  // drivers, all entered and left at a falling edge
  //--------------------------------------------------------------------------
  task automatic send_request(input req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, r.random_action, r.random_draw, r.following_state,
                      r.reward_value, r.taken_action, r.cur_state};
    s_axis_tuser  <= r.req_type;
    s_axis_tlast  <= r.episode_done;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    awaited_rsp = {awaited_rsp, next_q_response(r)};
    @(negedge clk_i);
  endtask

  task automatic write_register(input cfg_idx_e idx, input logic [16:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_register_write(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // stop offering requests and wait for every result plus the engine's latency
  task automatic settle_engine(input int limit);
    int guard;
    guard = 0;
    s_axis_tvalid <= 1'b0;
    while (awaited_rsp.size() != 0 && guard < limit) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (24) @(negedge clk_i);
  endtask

  function automatic req_t make_req(logic kind, int st, int act, logic [31:0] rew,
                                    int nxt, logic done, int draw, int ract);
    req_t r;
    r.req_type        = kind;
    r.cur_state       = st[7:0];
    r.taken_action    = act[2:0];
    r.reward_value    = rew;
    r.following_state = nxt[7:0];
    r.episode_done    = done;
    r.random_draw     = draw[15:0];
    r.random_action   = ract[2:0];
    return r;
  endfunction

  function automatic req_t random_req();
    logic [95:0] bits;
    bits = {$urandom, $urandom, $urandom};
    return bits[71:0];
  endfunction

  function automatic int pick_state();
    int rows;
    rows = active_rows();
    case ($urandom_range(9))
      0: return $urandom_range(255);
      1: return rows - 1;
      default: return $urandom_range(rows - 1);
    endcase
  endfunction

  function automatic logic [31:0] pick_reward();
    int v;
    case ($urandom_range(9))
      0: return $urandom;
      1: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: begin
        v = int'($urandom_range(1 << 19)) - (1 << 18);
        return v;
      end
    endcase
  endfunction

  function automatic logic [16:0] pick_fraction();
    case ($urandom_range(7))
      0: return 17'd0;
      1: return ONE_Q16;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(65536));
    endcase
  endfunction

  task automatic program_config(input logic [16:0] lr, disc, decay, flo, start, rows, acts);
    write_register(CFG_LEARN_RATE, lr);
    write_register(CFG_DISCOUNT, disc);
    write_register(CFG_EXPLORE_DECAY, decay);
    write_register(CFG_EXPLORE_FLOOR, flo);
    write_register(CFG_EXPLORE_START, start);
    write_register(CFG_STATES, rows);
    write_register(CFG_ACTIONS, acts);
  endtask

  // mostly choose-then-update episodes walking through states, some noise
  task automatic run_episodes(input int total);
    req_t r;
    int sent, len, st, nxt, i;
    sent = 0;
    while (sent < total) begin
      st = pick_state();
      len = $urandom_range(1, 10);
      for (i = 0; i < len && sent < total; i++) begin
        if ($urandom_range(99) < 80) begin
          r = random_req();
          r.req_type = REQ_CHOOSE;
          r.cur_state = st[7:0];
          send_request(r);
          nxt = pick_state();
          r = random_req();
          r.req_type = REQ_UPDATE;
          r.cur_state = st[7:0];
          r.following_state = nxt[7:0];
          r.reward_value = pick_reward();
          r.episode_done = (i == len - 1);
          send_request(r);
          sent += 2;
          st = nxt;
        end else begin
          send_request(random_req());
          sent++;
        end
      end
    end
  endtask

  //--------------------------------------------------------------------------
  // tests
  //--------------------------------------------------------------------------
  task automatic test_reset_defaults();
    send_request(make_req(REQ_CHOOSE, 0, 0, 32'h0, 0, 1'b0, 16'hFFFF, 7));
    send_request(make_req(REQ_UPDATE, 0, 0, 32'h7FFF_FFFF, 255, 1'b0, 0, 0));
    send_request(make_req(REQ_UPDATE, 255, 7, 32'h8000_0000, 0, 1'b1, 16'hFFFF, 7));
    send_request(make_req(REQ_CHOOSE, 255, 7, 32'hFFFF_FFFF, 255, 1'b1, 0, 0));
  endtask

  // equal entries in one row: greedy pick is the lowest index
  task automatic test_greedy_ties();
    settle_engine(100000);
    write_register(CFG_LEARN_RATE, ONE_Q16);
    write_register(CFG_DISCOUNT, 17'd0);
    write_register(CFG_EXPLORE_START, 17'd0);
    send_request(make_req(REQ_UPDATE, 3, 5, 32'd100 << 16, 0, 1'b0, 0, 0));
    send_request(make_req(REQ_UPDATE, 3, 2, 32'd100 << 16, 0, 1'b0, 0, 0));
    send_request(make_req(REQ_CHOOSE, 3, 0, 32'h0, 0, 1'b0, 16'hFFFF, 6));
    send_request(make_req(REQ_CHOOSE, 0, 0, 32'h0, 0, 1'b0, 16'hFFFF, 6));
    send_request(make_req(REQ_CHOOSE, 1, 0, 32'h0, 0, 1'b0, 16'hFFFF, 6));
  endtask

  // rates written above one act as one; the entry clamps both ways
  task automatic test_saturation();
    settle_engine(100000);
    write_register(CFG_LEARN_RATE, 17'h1FFFF);
    write_register(CFG_DISCOUNT, 17'h1FFFF);
    send_request(make_req(REQ_UPDATE, 4, 1, 32'h7FFF_FFFF, 4, 1'b0, 0, 0));
    send_request(make_req(REQ_UPDATE, 4, 1, 32'h7FFF_FFFF, 4, 1'b0, 0, 0));
    send_request(make_req(REQ_UPDATE, 5, 6, 32'h8000_0000, 5, 1'b0, 0, 0));
    send_request(make_req(REQ_UPDATE, 5, 6, 32'h8000_0000, 5, 1'b0, 0, 0));
  endtask

  // indexes past the rows and actions in use fall on the last one in use
  task automatic test_index_clamp();
    settle_engine(100000);
    write_register(CFG_STATES, 17'd4);
    write_register(CFG_ACTIONS, 17'd3);
    write_register(CFG_EXPLORE_START, ONE_Q16);
    send_request(make_req(REQ_UPDATE, 200, 7, 32'd1 << 16, 255, 1'b0, 0, 0));
    send_request(make_req(REQ_CHOOSE, 255, 7, 32'h0, 255, 1'b0, 0, 7));
    settle_engine(100000);
    // counts of zero, with junk above the register width
    write_register(CFG_STATES, 17'h1FE00);
    write_register(CFG_ACTIONS, 17'h1FFF0);
    send_request(make_req(REQ_CHOOSE, 9, 0, 32'h0, 0, 1'b0, 0, 5));
    send_request(make_req(REQ_UPDATE, 9, 5, 32'hFFFF_0000, 9, 1'b0, 0, 0));
  endtask

  // decay down to the floor, restart at one, episode end restart
  task automatic test_explore_floor();
    settle_engine(100000);
    program_config(LEARN_RATE_RST, DISCOUNT_RST, 17'd32768, 17'd30000, ONE_Q16,
                   17'(STATES_RST), 17'(ACTIONS_RST));
    send_request(make_req(REQ_UPDATE, 10, 1, 32'd5 << 16, 11, 1'b0, 0, 0));
    send_request(make_req(REQ_UPDATE, 11, 2, 32'd5 << 16, 12, 1'b0, 0, 0));
    send_request(make_req(REQ_UPDATE, 12, 3, 32'd5 << 16, 10, 1'b0, 0, 0));
    send_request(make_req(REQ_UPDATE, 10, 1, 32'd5 << 16, 11, 1'b1, 0, 0));
    settle_engine(100000);
    // floor at one: restart every time but no decay below
    write_register(CFG_EXPLORE_FLOOR, ONE_Q16);
    write_register(CFG_EXPLORE_DECAY, ONE_Q16);
    send_request(make_req(REQ_UPDATE, 10, 1, 32'd5 << 16, 11, 1'b0, 0, 0));
  endtask

  // rounds of random settings, the first all minimum and a later one all maximum
  task automatic test_random_traffic(input int tx_idle, input int rx_idle, input int items);
    int rnd;
    logic [16:0] rows, decay, flo;
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    for (rnd = 0; rnd < 3; rnd++) begin
      settle_engine(100000);
      if (round_no == 0) begin
        program_config('0, '0, '0, '0, '0, '0, '0);
      end else if (round_no == 4) begin
        program_config('1, '1, '1, '1, '1, '1, '1);
      end else begin
        case ($urandom_range(5))
          0: rows = 17'd256;
          1: rows = 17'($urandom_range(511));
          default: rows = 17'($urandom_range(1, 12));
        endcase
        rows[16:9] = 8'($urandom_range(255));
        decay = ($urandom_range(3) == 0) ? pick_fraction()
                                         : 17'($urandom_range(60000, 65536));
        flo = ($urandom_range(3) == 0) ? pick_fraction() : 17'($urandom_range(3000));
        program_config(pick_fraction(), pick_fraction(), decay, flo, pick_fraction(),
                       rows, 17'($urandom_range(131071)));
      end
      round_no++;
      run_episodes(items / 3);
    end
  endtask

  // long receiver hold-off with the sender pushing back to back
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk_i);
    hold_cycles_left = 300;
    @(negedge clk_i);
    run_episodes(40);
  endtask

  //--------------------------------------------------------------------------
  // sequence
  //--------------------------------------------------------------------------
  initial begin : run_tests
    int i;
    lr_q     = LEARN_RATE_RST;
    disc_q   = DISCOUNT_RST;
    decay_q  = EXPLORE_DECAY_RST;
    floor_q  = EXPLORE_FLOOR_RST;
    start_q  = EXPLORE_START_RST;
    rate_q   = ONE_Q16;
    rows_cfg = STATES_RST;
    acts_cfg = ACTIONS_RST;
    for (i = 0; i < MAX_ROWS*MAX_ACTS; i++) q_mirror[i] = '0;
    send_idle_pct = 34;
    recv_idle_pct = 54;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_defaults();
    test_greedy_ties();
    test_saturation();
    test_index_clamp();
    test_explore_floor();
    test_random_traffic(34, 54, 630);
    test_random_traffic(54, 34, 630);
    test_random_traffic(0, 0, 630);
    test_output_backpressure();

    settle_engine(20000);
    if (awaited_rsp.size() != 0)
      report_mismatch("results outstanding", 0, awaited_rsp.size());
    if (mismatch_count == 0) begin
      $display("q_table_learning_engine_unit test passed");
    end else begin
      $display("q_table_learning_engine_unit test failed");
    end
    $finish;
  end

endmodule
